/* rtl/psch_pkg.sv */
// shared types, codes and defaults of the priority task scheduler
package psch_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int LOCK_COUNT_DEF = 4;
  localparam logic [7:0] PRIO_IDLE = 8'd255;

  typedef enum logic [1:0] {
    MODE_SUSP,
    MODE_WAIT,
    MODE_READY,
    MODE_RUN
  } mode_t;

  typedef enum logic [2:0] {
    OP_CREATE,
    OP_ACTIVATE,
    OP_TERMINATE,
    OP_TIMED_WAIT,
    OP_TICK,
    OP_ACQUIRE,
    OP_RELEASE,
    OP_START
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_BLOCKED,
    ST_REFUSED,
    ST_IGNORED
  } status_t;

  // result of the shared key comparator
  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
  } cmp_t;

endpackage

/* rtl/priority_task_scheduler.sv */
// priority task scheduler top level: task table, ready queue, mutexes, sequencer
// steps: create, acquire and ignored words go from decode straight to the final step; a
//   reschedule adds a setup step, an insertion sort over the slot order, a best-priority
//   scan, a queueing scan when a task is runnable, and up to 2 pick steps
//   (S_PICK1, S_PICK2); a blocking acquire with inheritance adds an inheritance step
// tick adds a countdown sweep over every slot; one comparator does the sort, scan and pick compares
// throughput: one word at a time, busy stays high until the result strobe
// reset: synchronous active-low rst_n; only slot 0 (idle, priority 255) valid
// the result strobe lasts one cycle and the receiver cannot stall it
module priority_task_scheduler
  import psch_pkg::*;
#(
  parameter int TASK_SLOTS = TASK_SLOTS_DEF,
  parameter int LOCK_COUNT = LOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command word
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_ticks,
  input  logic [1:0]  in_mutex_id,
  // result word
  output logic        out_valid,
  output logic [3:0]  out_running_task,
  output logic        out_switch_request,
  output logic [4:0]  out_ready_count,
  output logic [1:0]  out_status,
  // inheritance enable register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam int LW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam logic [CW-1:0] NO_TASK = CW'(TASK_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TASK_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_PIA, S_SINIT, S_SORT, S_SCAN, S_PUSH,
    S_PICK1, S_PICK2, S_TICK, S_FIN
  } state_t;

  state_t state_r;

  // latched command word
  op_t         op_r;
  logic [3:0]  t_r;
  logic [7:0]  pr_r;
  logic [31:0] tk_r;
  logic [1:0]  m_r;

  // task table
  logic          valid_r [TASK_SLOTS];
  logic [7:0]    prio_r  [TASK_SLOTS];
  mode_t         mode_r  [TASK_SLOTS];
  logic          armed_r [TASK_SLOTS];
  logic [31:0]   wleft_r [TASK_SLOTS];
  logic          holds_r [TASK_SLOTS];
  logic [SW-1:0] ord_r   [TASK_SLOTS];
  logic [SW-1:0] fifo_r  [TASK_SLOTS];
  logic [SW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [SW-1:0] cur_r;
  logic          started_r;
  logic [3:0]    pi_en_r;

  // mutexes
  logic [CW-1:0] owner_r  [LOCK_COUNT];
  logic [CW-1:0] waiter_r [LOCK_COUNT];
  logic [7:0]    saved_r  [LOCK_COUNT];

  // sequencer working registers
  logic [SW-1:0] i_r;
  logic [SW-1:0] j_r;
  logic [SW-1:0] v_r;
  logic [SW-1:0] nxt_r;
  logic [SW-1:0] last_r;
  logic          found_r;
  logic          any_r;
  logic [8:0]    best_r;
  logic [7:0]    aux_r;
  logic          tick_r;
  logic          expired_r;
  logic          sw_r;
  status_t       status_r;

  // output registers
  logic          out_valid_r;
  logic [3:0]    out_run_r;
  logic          out_sw_r;
  logic [4:0]    out_cnt_r;
  logic [1:0]    out_st_r;

  // decoded command
  logic          t_in_range;
  logic [SW-1:0] t_idx;
  logic          t_ok;
  logic          m_ok;
  logic [LW-1:0] m_idx;
  logic          pi;
  logic [SW-1:0] own_idx;
  logic [SW-1:0] w_idx;

  assign t_in_range = 32'(t_r) < TASK_SLOTS;
  assign t_idx      = SW'(t_r);
  assign t_ok       = t_in_range && (op_r == OP_CREATE || valid_r[t_idx]);
  assign m_ok       = 32'(m_r) < LOCK_COUNT;
  assign m_idx      = LW'(m_r);
  assign pi         = m_ok && pi_en_r[m_r];
  assign own_idx    = SW'(owner_r[m_idx]);
  assign w_idx      = SW'(waiter_r[m_idx]);

  function automatic logic [8:0] key_of(input logic v, input logic [7:0] p);
    return v ? {1'b0, p} : 9'd256;
  endfunction

  // ready queue tail slot
  logic [SW:0]   tail_sum;
  logic [SW-1:0] tail_idx;
  logic [SW-1:0] head_inc;
  logic          can_push;

  always_comb begin
    tail_sum = (SW + 1)'(head_r) + (SW + 1)'(count_r);
    if (tail_sum >= (SW + 1)'(TASK_SLOTS)) begin
      tail_sum = tail_sum - (SW + 1)'(TASK_SLOTS);
    end
    tail_idx = tail_sum[SW-1:0];
    head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
    can_push = count_r < NO_TASK;
  end

  // shared comparator operand select
  logic [SW-1:0] scan_s;
  logic [SW-1:0] prev_s;
  logic [8:0]    cmp_a;
  logic [8:0]    cmp_b;
  cmp_t          cmp;

  assign scan_s = ord_r[i_r];
  assign prev_s = ord_r[j_r - 1'b1];

  always_comb begin
    cmp_a = key_of(valid_r[prev_s], prio_r[prev_s]);
    cmp_b = key_of(valid_r[v_r], prio_r[v_r]);
    case (state_r)
      S_SCAN, S_PUSH: begin
        cmp_a = {1'b0, prio_r[scan_s]};
        cmp_b = best_r;
      end
      S_PICK2: begin
        cmp_a = {1'b0, aux_r};
        cmp_b = {1'b0, prio_r[nxt_r]};
      end
      default: ;
    endcase
  end

  psch_cmp u_cmp (
    .key_a(cmp_a),
    .key_b(cmp_b),
    .res  (cmp)
  );

  logic [31:0] wl_dec;
  assign wl_dec = wleft_r[i_r] - 32'd1;

  // pick decision after a reschedule
  logic want_pick;
  assign want_pick = tick_r ? started_r : (started_r && cur_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      cur_r     <= '0;
      started_r <= 1'b0;
      pi_en_r   <= '0;
      for (int k = 0; k < TASK_SLOTS; k++) begin
        valid_r[k] <= (k == 0);
        prio_r[k]  <= (k == 0) ? PRIO_IDLE : 8'd0;
        mode_r[k]  <= MODE_SUSP;
        armed_r[k] <= 1'b0;
        holds_r[k] <= 1'b0;
        ord_r[k]   <= SW'(k);
      end
      for (int k = 0; k < LOCK_COUNT; k++) begin
        owner_r[k]  <= NO_TASK;
        waiter_r[k] <= NO_TASK;
        saved_r[k]  <= '0;
      end
    end else begin
      // the result strobe is registered from the final step and rises in the cycle after it
      out_valid_r <= (state_r == S_FIN);
      if (cfg_valid && cfg_ready) begin
        pi_en_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r    <= op_t'(in_operation);
            t_r     <= in_task_id;
            pr_r    <= in_priority_req;
            tk_r    <= in_ticks;
            m_r     <= in_mutex_id;
            state_r <= S_EXEC;
          end
        end

        S_EXEC: begin
          status_t st_v;
          state_t  nx_v;
          st_v      = ST_DONE;
          nx_v      = S_FIN;
          sw_r      <= 1'b0;
          tick_r    <= (op_r == OP_TICK);
          expired_r <= 1'b0;
          case (op_r)
            OP_CREATE: begin
              if (!t_ok || valid_r[t_idx]) begin
                st_v = ST_IGNORED;
              end else begin
                valid_r[t_idx] <= 1'b1;
                prio_r[t_idx]  <= pr_r;
                mode_r[t_idx]  <= MODE_SUSP;
                armed_r[t_idx] <= 1'b0;
                holds_r[t_idx] <= 1'b0;
                // remove the slot from the order and append it at the end
                for (int k = 0; k < TASK_SLOTS; k++) begin
                  logic seen;
                  seen = 1'b0;
                  for (int q = 0; q <= k; q++) begin
                    if (ord_r[q] == t_idx) seen = 1'b1;
                  end
                  if (k == TASK_SLOTS - 1) begin
                    ord_r[k] <= t_idx;
                  end else if (seen) begin
                    ord_r[k] <= ord_r[k+1];
                  end
                end
              end
            end
            OP_ACTIVATE, OP_TERMINATE, OP_TIMED_WAIT: begin
              if (!t_ok) begin
                st_v = ST_IGNORED;
              end else begin
                if (op_r == OP_TIMED_WAIT) begin
                  armed_r[t_idx] <= 1'b1;
                  wleft_r[t_idx] <= tk_r;
                end
                mode_r[t_idx] <= (op_r == OP_ACTIVATE) ? MODE_WAIT : MODE_SUSP;
                nx_v = S_SINIT;
              end
            end
            OP_TICK: begin
              i_r  <= '0;
              nx_v = S_TICK;
            end
            OP_ACQUIRE: begin
              if (!t_ok || !m_ok) begin
                st_v = ST_IGNORED;
              end else if (owner_r[m_idx] >= NO_TASK) begin
                owner_r[m_idx] <= CW'(t_idx);
                holds_r[t_idx] <= 1'b1;
              end else if (waiter_r[m_idx] < NO_TASK) begin
                st_v = ST_IGNORED;
              end else if (holds_r[t_idx]) begin
                st_v = ST_REFUSED;
              end else begin
                waiter_r[m_idx] <= CW'(t_idx);
                mode_r[t_idx]   <= MODE_SUSP;
                holds_r[t_idx]  <= 1'b1;
                st_v            = ST_BLOCKED;
                aux_r           <= prio_r[t_idx];
                nx_v            = pi ? S_PIA : S_SINIT;
              end
            end
            OP_RELEASE: begin
              if (!t_ok || !m_ok || owner_r[m_idx] != CW'(t_idx)) begin
                st_v = ST_IGNORED;
              end else begin
                holds_r[t_idx] <= 1'b0;
                if (waiter_r[m_idx] >= NO_TASK) begin
                  owner_r[m_idx] <= NO_TASK;
                end else begin
                  if (pi) begin
                    prio_r[t_idx]  <= saved_r[m_idx];
                    saved_r[m_idx] <= prio_r[w_idx];
                  end
                  owner_r[m_idx]  <= waiter_r[m_idx];
                  waiter_r[m_idx] <= NO_TASK;
                  mode_r[w_idx]   <= MODE_READY;
                  nx_v            = S_SINIT;
                end
              end
            end
            OP_START: begin
              if (started_r) begin
                st_v = ST_IGNORED;
              end else begin
                started_r <= 1'b1;
                cur_r     <= '0;
                mode_r[0] <= MODE_WAIT;
                nx_v      = S_SINIT;
              end
            end
            default: st_v = ST_IGNORED;
          endcase
          status_r <= st_v;
          state_r  <= nx_v;
        end

        // inheritance: raise the owner to the waiter priority
        S_PIA: begin
          saved_r[m_idx] <= prio_r[own_idx];
          if (aux_r < prio_r[own_idx]) begin
            prio_r[own_idx] <= aux_r;
          end
          state_r <= S_SINIT;
        end

        S_SINIT: begin
          i_r     <= SW'(1);
          j_r     <= SW'(1);
          v_r     <= ord_r[1];
          state_r <= S_SORT;
        end

        // insertion sort, one compare per cycle
        S_SORT: begin
          if (j_r != '0 && cmp.gt) begin
            ord_r[j_r] <= prev_s;
            j_r        <= j_r - 1'b1;
          end else begin
            ord_r[j_r] <= v_r;
            if (i_r == LAST_IDX) begin
              i_r     <= '0;
              head_r  <= '0;
              count_r <= '0;
              best_r  <= 9'd256;
              any_r   <= 1'b0;
              found_r <= 1'b0;
              state_r <= S_SCAN;
            end else begin
              i_r <= i_r + 1'b1;
              j_r <= i_r + 1'b1;
              v_r <= ord_r[i_r + 1'b1];
            end
          end
        end

        // find best priority among non-suspended tasks
        S_SCAN: begin
          logic upd_any;
          upd_any = valid_r[scan_s] && mode_r[scan_s] != MODE_SUSP && cmp.lt;
          if (valid_r[scan_s]) begin
            last_r  <= scan_s;
            found_r <= 1'b1;
          end
          if (upd_any) begin
            best_r <= {1'b0, prio_r[scan_s]};
            any_r  <= 1'b1;
          end
          if (i_r == LAST_IDX) begin
            i_r <= '0;
            if (any_r || upd_any) begin
              state_r <= S_PUSH;
            end else begin
              // nothing runnable: queue the last valid slot in order
              if (valid_r[scan_s]) begin
                fifo_r[tail_idx] <= scan_s;
                count_r          <= count_r + 1'b1;
                mode_r[scan_s]   <= MODE_READY;
              end else if (found_r) begin
                fifo_r[tail_idx] <= last_r;
                count_r          <= count_r + 1'b1;
                mode_r[last_r]   <= MODE_READY;
              end
              state_r <= want_pick ? S_PICK1 : S_FIN;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_PUSH: begin
          if (valid_r[scan_s] && mode_r[scan_s] != MODE_SUSP && cmp.eq) begin
            if (can_push) begin
              fifo_r[tail_idx] <= scan_s;
              count_r          <= count_r + 1'b1;
            end
            mode_r[scan_s] <= MODE_READY;
          end
          if (i_r == LAST_IDX) begin
            state_r <= want_pick ? S_PICK1 : S_FIN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_PICK1: begin
          sw_r  <= 1'b1;
          aux_r <= prio_r[cur_r];
          if (count_r == '0) begin
            if (mode_r[cur_r] != MODE_SUSP) begin
              mode_r[cur_r] <= MODE_RUN;
              if (can_push) begin
                fifo_r[tail_idx] <= cur_r;
                count_r          <= count_r + 1'b1;
              end
            end
            state_r <= S_FIN;
          end else begin
            nxt_r                 <= fifo_r[head_r];
            head_r                <= head_inc;
            count_r               <= count_r - 1'b1;
            mode_r[fifo_r[head_r]] <= MODE_RUN;
            state_r               <= S_PICK2;
          end
        end

        // rotate the outgoing task if it shares the priority
        S_PICK2: begin
          if (cmp.eq && mode_r[cur_r] != MODE_SUSP) begin
            if (can_push) begin
              fifo_r[tail_idx] <= cur_r;
              count_r          <= count_r + 1'b1;
            end
            mode_r[cur_r] <= MODE_READY;
          end
          cur_r   <= nxt_r;
          state_r <= S_FIN;
        end

        // countdown sweep, one slot per cycle
        S_TICK: begin
          logic hit;
          hit = valid_r[i_r] && mode_r[i_r] == MODE_SUSP && armed_r[i_r];
          if (hit) begin
            wleft_r[i_r] <= wl_dec;
            if (wl_dec == 32'd0) begin
              armed_r[i_r] <= 1'b0;
              mode_r[i_r]  <= MODE_WAIT;
              expired_r    <= 1'b1;
            end
          end
          if (i_r == LAST_IDX) begin
            if (expired_r || (hit && wl_dec == 32'd0)) begin
              state_r <= S_SINIT;
            end else begin
              state_r <= started_r ? S_PICK1 : S_FIN;
            end
          end else begin
            i_r <= i_r + 1'b1;
          end
        end

        S_FIN: begin
          out_run_r   <= 4'(cur_r);
          out_sw_r    <= sw_r;
          out_cnt_r   <= 5'(count_r);
          out_st_r    <= status_r;
          state_r     <= S_IDLE;
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = state_r != S_IDLE;
  assign cfg_ready          = !busy;
  assign out_valid          = out_valid_r;
  assign out_running_task   = out_run_r;
  assign out_switch_request = out_sw_r;
  assign out_ready_count    = out_cnt_r;
  assign out_status         = out_st_r;

  // a result word only comes out of the final step
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without final step");

  // an accepted word always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not start work");

  // the ready queue never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NO_TASK)
    else $error("ready queue count overflow");

  // the running slot is always a live task
  a_cur_valid: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[cur_r])
    else $error("running slot not valid");

endmodule

/* rtl/psch_cmp.sv */
// shared 9-bit key comparator used by sort, scan and pick steps
module psch_cmp
  import psch_pkg::*;
(
  input  logic [8:0] key_a,
  input  logic [8:0] key_b,
  output cmp_t       res
);

  always_comb begin
    res.gt = key_a > key_b;
    res.lt = key_a < key_b;
    res.eq = key_a == key_b;
  end

endmodule
